### hdl/meo_pkg.sv
// Package: widths, command codes and types for the midpoint ellipse outline block.
`default_nettype none

package meo_pkg;

    localparam int RADIUS_BITS = 10;
    localparam int COORD_BITS  = 12;

    localparam int PIX_BITS = COORD_BITS + 1;
    localparam int STEPX_W  = RADIUS_BITS + 1;
    localparam int STEPY_W  = RADIUS_BITS + 2;
    localparam int SQ_W     = 2 * RADIUS_BITS;
    localparam int GRAD_W   = 3 * RADIUS_BITS + 4;
    localparam int DEC_W    = 4 * RADIUS_BITS + 8;
    localparam int MUL_W    = 2 * RADIUS_BITS + 4;
    localparam int PROD_W   = 2 * MUL_W;

    // command codes carried by mode
    localparam logic MODE_START   = 1'b0;
    localparam logic MODE_ADVANCE = 1'b1;

    typedef logic        [RADIUS_BITS-1:0] radius_t;
    typedef logic signed [COORD_BITS-1:0]  coord_t;
    typedef logic signed [PIX_BITS-1:0]    pix_t;

endpackage

`default_nettype wire

### hdl/meo_cmd_if.sv
// Interface: command channel (start / advance transactions).
`default_nettype none

interface meo_cmd_if
    import meo_pkg::*;
();
    logic    valid;
    logic    ready;
    logic    mode;
    radius_t radius_x;
    radius_t radius_y;
    coord_t  centre_x;
    coord_t  centre_y;

    modport source (output valid, output mode, output radius_x, output radius_y,
                    output centre_x, output centre_y, input ready);
    modport sink   (input valid, input mode, input radius_x, input radius_y,
                    input centre_x, input centre_y, output ready);
endinterface

`default_nettype wire

### hdl/meo_pix_if.sv
// Interface: pixel result channel.
`default_nettype none

interface meo_pix_if
    import meo_pkg::*;
();
    logic valid;
    logic ready;
    pix_t pixel_x;
    pix_t pixel_y;
    logic done_res;
    logic last;

    modport source (output valid, output pixel_x, output pixel_y, output done_res,
                    output last, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, input done_res,
                    input last, output ready);
endinterface

`default_nettype wire

### hdl/midpoint_ellipse_outline.sv
// Top level: two-region midpoint ellipse outline rasterizer.
//
//  channel | dir | payload                                   | transaction
//  --------+-----+-------------------------------------------+---------------------------
//  cmd     | in  | mode, radius_x, radius_y, centre_x/_y     | start or advance one step
//  pix     | out | pixel_x, pixel_y, done_res, last          | one pixel, or done marker
//
//  Start: accept, then states M0..M4, with the shared multiplier used in M0..M2.
//  Advance: accept, four pixels in EMIT (held while pix stalls), then UPD_A, UPD_B;
//  the region switch first runs SW0..SW5 on the shared multiplier.
//  Finished/idle advance: accept, then FIN sends the done transaction.
//  One item at a time: cmd.ready is high only while the sequencer is idle.
//  pix stalls hold the pixel loop; a registered output slot lets the next
//  command be taken while the last result still waits.
//  Reset (rst_n low, async) returns to idle and clears control state; payload registers are not reset.
`default_nettype none

module midpoint_ellipse_outline
    import meo_pkg::*;
(
    input  wire       clk,
    input  wire       rst_n,
    meo_cmd_if.sink   cmd,
    meo_pix_if.source pix
);

    // walk phase
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_R1   = 2'd1;
    localparam logic [1:0] PH_R2   = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;

    // sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_M0    = 4'd1;   // rx*rx
    localparam logic [3:0] ST_M1    = 4'd2;   // ry*ry
    localparam logic [3:0] ST_M2    = 4'd3;   // rx2*ry
    localparam logic [3:0] ST_M3    = 4'd4;
    localparam logic [3:0] ST_M4    = 4'd5;
    localparam logic [3:0] ST_SW0   = 4'd6;   // tx*tx
    localparam logic [3:0] ST_SW1   = 4'd7;   // ry2*tx2
    localparam logic [3:0] ST_SW2   = 4'd8;   // ty*ty
    localparam logic [3:0] ST_SW3   = 4'd9;   // rx2*ty2
    localparam logic [3:0] ST_SW4   = 4'd10;  // rx2*ry2
    localparam logic [3:0] ST_SW5   = 4'd11;
    localparam logic [3:0] ST_EMIT  = 4'd12;
    localparam logic [3:0] ST_UPD_A = 4'd13;
    localparam logic [3:0] ST_UPD_B = 4'd14;
    localparam logic [3:0] ST_FIN   = 4'd15;

    // ---------------- registers ----------------
    logic [3:0]                state_reg, state_next;
    logic [1:0]                phase_reg, phase_next;
    logic [1:0]                k_reg, k_next;
    logic [STEPX_W-1:0]        step_x_reg, step_x_next;
    logic signed [STEPY_W-1:0] step_y_reg, step_y_next;
    logic signed [GRAD_W-1:0]  grad_x_reg, grad_x_next;
    logic signed [GRAD_W-1:0]  grad_y_reg, grad_y_next;
    logic signed [DEC_W-1:0]   dec_reg, dec_next;
    radius_t                   rx_reg, rx_next;
    radius_t                   ry_reg, ry_next;
    coord_t                    cx_reg, cx_next;
    coord_t                    cy_reg, cy_next;
    logic [SQ_W-1:0]           rx2_reg, rx2_next;
    logic [SQ_W-1:0]           ry2_reg, ry2_next;
    logic [PROD_W-1:0]         prod_reg, prod_next;
    logic                      out_valid_reg, out_valid_next;
    pix_t                      px_reg, px_next;
    pix_t                      py_reg, py_next;
    logic                      done_reg, done_next;
    logic                      last_reg, last_next;

    // ---------------- shared multiplier ----------------
    logic [MUL_W-1:0] mul_a;
    logic [MUL_W-1:0] mul_b;

    assign prod_next = mul_a * mul_b;

    // region switch operands: tx = 2x+1, ty = y-1 (y >= 0 here, so |ty| fits)
    logic [STEPX_W:0]          tx;
    logic signed [STEPY_W-1:0] ty;
    logic [STEPY_W-1:0]        ty_abs;

    assign tx     = {step_x_reg, 1'b1};
    assign ty     = step_y_reg - STEPY_W'(1);
    assign ty_abs = ty[STEPY_W-1] ? STEPY_W'(-ty) : STEPY_W'(ty);

    // decision sign tests
    logic dec_neg;
    logic dec_pos;

    assign dec_neg = dec_reg[DEC_W-1];
    assign dec_pos = !dec_reg[DEC_W-1] && (dec_reg != '0);

    // step increment terms
    logic signed [GRAD_W-1:0] two_rx2;
    logic signed [GRAD_W-1:0] two_ry2;

    assign two_rx2 = GRAD_W'({rx2_reg, 1'b0});
    assign two_ry2 = GRAD_W'({ry2_reg, 1'b0});

    // decision update: 4 * (gx? - gy? + sq)
    logic                     use_gx;
    logic                     use_gy;
    logic [SQ_W-1:0]          upd_sq;
    logic signed [DEC_W-1:0]  dec_term;

    always_comb
    begin
        if (phase_reg == PH_R2)
        begin
            use_gx = !dec_pos;
            use_gy = 1'b1;
            upd_sq = rx2_reg;
        end
        else
        begin
            use_gx = 1'b1;
            use_gy = !dec_neg;
            upd_sq = ry2_reg;
        end
    end

    assign dec_term = (use_gx ? DEC_W'(grad_x_reg) : '0)
                    - (use_gy ? DEC_W'(grad_y_reg) : '0)
                    + $signed(DEC_W'(upd_sq));

    // symmetric pixel for quadrant k: bit 0 flips x, bit 1 flips y
    pix_t cx_ext;
    pix_t cy_ext;
    pix_t sx_ext;
    pix_t sy_ext;
    pix_t quad_x;
    pix_t quad_y;

    assign cx_ext = PIX_BITS'(cx_reg);
    assign cy_ext = PIX_BITS'(cy_reg);
    assign sx_ext = PIX_BITS'($signed({1'b0, step_x_reg}));
    assign sy_ext = PIX_BITS'(step_y_reg);
    assign quad_x = k_reg[0] ? (cx_ext - sx_ext) : (cx_ext + sx_ext);
    assign quad_y = k_reg[1] ? (cy_ext - sy_ext) : (cy_ext + sy_ext);

    logic slot_free;

    assign slot_free = !out_valid_reg || pix.ready;

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        k_next      = k_reg;
        step_x_next = step_x_reg;
        step_y_next = step_y_reg;
        grad_x_next = grad_x_reg;
        grad_y_next = grad_y_reg;
        dec_next    = dec_reg;
        rx_next     = rx_reg;
        ry_next     = ry_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        rx2_next    = rx2_reg;
        ry2_next    = ry2_reg;
        mul_a       = '0;
        mul_b       = '0;

        out_valid_next = out_valid_reg && !pix.ready;
        px_next        = px_reg;
        py_next        = py_reg;
        done_next      = done_reg;
        last_next      = last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    if (cmd.mode == MODE_START)
                    begin
                        rx_next     = cmd.radius_x;
                        ry_next     = cmd.radius_y;
                        cx_next     = cmd.centre_x;
                        cy_next     = cmd.centre_y;
                        step_x_next = '0;
                        step_y_next = $signed({2'b00, cmd.radius_y});
                        grad_x_next = '0;
                        phase_next  = PH_R1;
                        state_next  = ST_M0;
                    end
                    else
                    begin
                        k_next = '0;
                        case (phase_reg)
                            PH_R1:
                            begin
                                if (grad_x_reg < grad_y_reg)
                                    state_next = ST_EMIT;
                                else
                                    state_next = ST_SW0;
                            end
                            PH_R2:
                            begin
                                if (!step_y_reg[STEPY_W-1])
                                    state_next = ST_EMIT;
                                else
                                begin
                                    phase_next = PH_DONE;
                                    state_next = ST_FIN;
                                end
                            end
                            default:
                            begin
                                state_next = ST_FIN;
                            end
                        endcase
                    end
                end
            end

            // start setup
            ST_M0:
            begin
                mul_a      = MUL_W'(rx_reg);
                mul_b      = MUL_W'(rx_reg);
                state_next = ST_M1;
            end
            ST_M1:
            begin
                rx2_next   = prod_reg[SQ_W-1:0];
                mul_a      = MUL_W'(ry_reg);
                mul_b      = MUL_W'(ry_reg);
                state_next = ST_M2;
            end
            ST_M2:
            begin
                ry2_next   = prod_reg[SQ_W-1:0];
                mul_a      = MUL_W'(rx2_reg);
                mul_b      = MUL_W'(ry_reg);
                state_next = ST_M3;
            end
            ST_M3:
            begin
                grad_y_next = $signed(GRAD_W'({prod_reg, 1'b0}));
                dec_next    = $signed(DEC_W'({ry2_reg, 2'b00})) + $signed(DEC_W'(rx2_reg));
                state_next  = ST_M4;
            end
            ST_M4:
            begin
                // 4*rx2*ry = 2*grad_y
                dec_next   = dec_reg - (DEC_W'(grad_y_reg) <<< 1);
                state_next = ST_IDLE;
            end

            // region 2 decision: ry2*tx^2 + 4*rx2*ty^2 - 4*rx2*ry2
            ST_SW0:
            begin
                mul_a      = MUL_W'(tx);
                mul_b      = MUL_W'(tx);
                state_next = ST_SW1;
            end
            ST_SW1:
            begin
                mul_a      = MUL_W'(ry2_reg);
                mul_b      = prod_reg[MUL_W-1:0];
                state_next = ST_SW2;
            end
            ST_SW2:
            begin
                dec_next   = $signed(DEC_W'(prod_reg));
                mul_a      = MUL_W'(ty_abs);
                mul_b      = MUL_W'(ty_abs);
                state_next = ST_SW3;
            end
            ST_SW3:
            begin
                mul_a      = MUL_W'(rx2_reg);
                mul_b      = prod_reg[MUL_W-1:0];
                state_next = ST_SW4;
            end
            ST_SW4:
            begin
                dec_next   = dec_reg + $signed(DEC_W'({prod_reg, 2'b00}));
                mul_a      = MUL_W'(rx2_reg);
                mul_b      = MUL_W'(ry2_reg);
                state_next = ST_SW5;
            end
            ST_SW5:
            begin
                dec_next   = dec_reg - $signed(DEC_W'({prod_reg, 2'b00}));
                if (!step_y_reg[STEPY_W-1])
                begin
                    phase_next = PH_R2;
                    state_next = ST_EMIT;
                end
                else
                begin
                    phase_next = PH_DONE;
                    state_next = ST_FIN;
                end
            end

            // four symmetric pixels, last on the fourth
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    px_next        = quad_x;
                    py_next        = quad_y;
                    done_next      = 1'b0;
                    last_next      = (k_reg == 2'd3);
                    k_next         = k_reg + 2'd1;
                    if (k_reg == 2'd3)
                        state_next = ST_UPD_A;
                end
            end

            ST_UPD_A:
            begin
                if (phase_reg == PH_R2)
                begin
                    step_y_next = step_y_reg - STEPY_W'(1);
                    grad_y_next = grad_y_reg - two_rx2;
                    if (!dec_pos)
                    begin
                        step_x_next = step_x_reg + STEPX_W'(1);
                        grad_x_next = grad_x_reg + two_ry2;
                    end
                end
                else
                begin
                    step_x_next = step_x_reg + STEPX_W'(1);
                    grad_x_next = grad_x_reg + two_ry2;
                    if (!dec_neg)
                    begin
                        step_y_next = step_y_reg - STEPY_W'(1);
                        grad_y_next = grad_y_reg - two_rx2;
                    end
                end
                state_next = ST_UPD_B;
            end

            ST_UPD_B:
            begin
                dec_next   = dec_reg + (dec_term <<< 2);
                state_next = ST_IDLE;
            end

            ST_FIN:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    px_next        = '0;
                    py_next        = '0;
                    done_next      = 1'b1;
                    last_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_IDLE;
            k_reg         <= '0;
            step_x_reg    <= '0;
            step_y_reg    <= '0;
            grad_x_reg    <= '0;
            grad_y_reg    <= '0;
            dec_reg       <= '0;
            rx_reg        <= '0;
            ry_reg        <= '0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            rx2_reg       <= '0;
            ry2_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            k_reg         <= k_next;
            step_x_reg    <= step_x_next;
            step_y_reg    <= step_y_next;
            grad_x_reg    <= grad_x_next;
            grad_y_reg    <= grad_y_next;
            dec_reg       <= dec_next;
            rx_reg        <= rx_next;
            ry_reg        <= ry_next;
            cx_reg        <= cx_next;
            cy_reg        <= cy_next;
            rx2_reg       <= rx2_next;
            ry2_reg       <= ry2_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload: no reset
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        px_reg   <= px_next;
        py_reg   <= py_next;
        done_reg <= done_next;
        last_reg <= last_next;
    end

    assign cmd.ready    = (state_reg == ST_IDLE);
    assign pix.valid    = out_valid_reg;
    assign pix.pixel_x  = px_reg;
    assign pix.pixel_y  = py_reg;
    assign pix.done_res = done_reg;
    assign pix.last     = last_reg;

    // ---------------- assertions ----------------
    a_phase_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_IDLE) |=> (phase_reg != PH_IDLE))
        else $error("walk phase fell back to idle");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |=> !cmd.ready)
        else $error("command taken while previous one in progress");

    a_done_marker: assert property (@(posedge clk) disable iff (!rst_n)
        (pix.valid && pix.done_res) |-> (pix.last && pix.pixel_x == '0 && pix.pixel_y == '0))
        else $error("done transaction malformed");

    a_emit_in_region: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (phase_reg == PH_R1 || phase_reg == PH_R2))
        else $error("pixels emitted outside a region");

endmodule

`default_nettype wire
